### hw/rtl/cabe_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cabe_pkg
// Shared types and constants of the cell attribute byte encoder.
// ----------------------------------------------------------------------------
package cabe_pkg;

  localparam int unsigned NPIX     = 6;
  localparam int unsigned PIX_W    = 3;
  localparam int unsigned BMP_W    = NPIX;
  localparam int unsigned BYTE_W   = 7;
  localparam int unsigned CNT_W    = 3;
  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned PTR_W    = $clog2(FIFO_DEPTH);
  localparam int unsigned FCNT_W   = $clog2(FIFO_DEPTH + 1);

  localparam logic [BYTE_W-1:0] BITMAP_BASE   = 7'd64;
  localparam logic [PIX_W-1:0]  DEFAULT_COLOR = 3'd7;

  localparam logic CFG_COLOR_MODE    = 1'b0;
  localparam logic CFG_LIT_THRESHOLD = 1'b1;

  typedef struct packed {
    logic             held_lit;
    logic             in_lit;
    logic [7:1]       in_hot;
  } lane_t;

  typedef struct packed {
    logic [BMP_W-1:0] held_bmp;
    logic [CNT_W-1:0] held_cnt;
    logic [BMP_W-1:0] in_bmp;
    logic [CNT_W-1:0] in_cnt;
    logic [PIX_W-1:0] in_dom;
  } merge_t;

  typedef struct packed {
    logic [BYTE_W-1:0] out_byte;
    logic              is_attribute;
    logic              last_of_run;
  } res_t;

endpackage

### hw/rtl/cabe_lane.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cabe_lane
// Per-pixel lane: lit tests for held and incoming pixel, colour decode.
// ----------------------------------------------------------------------------
module cabe_lane
  import cabe_pkg::*;
(
  input  logic [PIX_W-1:0] held_pix_i,
  input  logic [PIX_W-1:0] in_pix_i,
  output lane_t            lane_o
);

  always_comb begin
    lane_o.held_lit = (held_pix_i != '0);
    lane_o.in_lit   = (in_pix_i != '0);
    for (int c = 1; c < 8; c++) begin
      lane_o.in_hot[c] = (in_pix_i == PIX_W'(c));
    end
  end

endmodule

### hw/rtl/cabe_merge.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cabe_merge
// Combines lane results: bitmaps, lit counts and dominant lookahead colour.
// ----------------------------------------------------------------------------
module cabe_merge
  import cabe_pkg::*;
(
  input  lane_t  lanes_i [NPIX],
  output merge_t merge_o
);

  logic [CNT_W-1:0] hist [1:7];
  logic [CNT_W-1:0] best_n;
  logic [PIX_W-1:0] best;
  logic [CNT_W-1:0] held_cnt;
  logic [CNT_W-1:0] in_cnt;

  always_comb begin
    held_cnt = '0;
    in_cnt   = '0;
    for (int i = 0; i < NPIX; i++) begin
      merge_o.held_bmp[BMP_W-1-i] = lanes_i[i].held_lit;
      merge_o.in_bmp[BMP_W-1-i]   = lanes_i[i].in_lit;
      held_cnt = held_cnt + CNT_W'(lanes_i[i].held_lit);
      in_cnt   = in_cnt + CNT_W'(lanes_i[i].in_lit);
    end
    merge_o.held_cnt = held_cnt;
    merge_o.in_cnt   = in_cnt;
  end

  always_comb begin
    for (int c = 1; c < 8; c++) begin
      hist[c] = '0;
      for (int i = 0; i < NPIX; i++) begin
        hist[c] = hist[c] + CNT_W'(lanes_i[i].in_hot[c]);
      end
    end
  end

  // ties go to the higher colour
  always_comb begin
    best   = 3'd1;
    best_n = hist[1];
    for (int c = 2; c < 8; c++) begin
      if (hist[c] >= best_n) begin
        best   = PIX_W'(c);
        best_n = hist[c];
      end
    end
    merge_o.in_dom = best;
  end

endmodule

### hw/rtl/cabe_res_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cabe_res_fifo
// Result queue taking up to two results per cycle, draining one per cycle while the output is ready.
// ----------------------------------------------------------------------------
module cabe_res_fifo
  import cabe_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic [1:0]  push_n_i,
  input  res_t        push_d0_i,
  input  res_t        push_d1_i,
  output logic        space2_o,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output res_t        out_res_o
);

  res_t              mem_q [FIFO_DEPTH];
  logic [PTR_W-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0]  rd_ptr_q, rd_ptr_d;
  logic [FCNT_W-1:0] count_q, count_d;
  logic              pop;
  logic [PTR_W-1:0]  wr_ptr_nx;

  assign pop         = out_valid_o && out_ready_i;
  assign out_valid_o = (count_q != '0);
  assign out_res_o   = mem_q[rd_ptr_q];
  assign space2_o    = (count_q <= FCNT_W'(FIFO_DEPTH - 2));
  assign wr_ptr_nx   = wr_ptr_q + PTR_W'(1);

  always_comb begin
    wr_ptr_d = wr_ptr_q + PTR_W'(push_n_i);
    rd_ptr_d = rd_ptr_q + PTR_W'(pop);
    count_d  = count_q + FCNT_W'(push_n_i) - FCNT_W'(pop);
  end

  always_ff @(posedge clk_i) begin
    if (push_n_i != 2'd0) begin
      mem_q[wr_ptr_q] <= push_d0_i;
    end
    if (push_n_i == 2'd2) begin
      mem_q[wr_ptr_nx] <= push_d1_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= FCNT_W'(FIFO_DEPTH))
    else $error("result queue overfilled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_n_i == 2'd0 && !pop) |=> $stable(count_q))
    else $error("queue level moved without transaction");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_n_i != 2'd0) |-> (count_q + FCNT_W'(push_n_i) <= FCNT_W'(FIFO_DEPTH)))
    else $error("push beyond free space");

endmodule

### hw/rtl/cell_attribute_byte_encoder_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cell_attribute_byte_encoder_top
// Six-pixel cell to screen byte encoder, mono bitmap or colour attributes.
// ----------------------------------------------------------------------------
// each result is written into the result queue when a cell is accepted and is offered from the queue head
// throughput: one cell per cycle while each cell gives at most one byte and the output is ready
// in colour mode a row-end cell with a held cell gives two bytes, limited by the one-byte
//   output port draining a four-entry result queue
// reset: mono mode, threshold 0, no held cell, current colour 7, queue empty
module cell_attribute_byte_encoder_top
  import cabe_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic              cfg_idx_i,
  input  logic [2:0]        cfg_wdata_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [PIX_W-1:0]  pixel_0_i,
  input  logic [PIX_W-1:0]  pixel_1_i,
  input  logic [PIX_W-1:0]  pixel_2_i,
  input  logic [PIX_W-1:0]  pixel_3_i,
  input  logic [PIX_W-1:0]  pixel_4_i,
  input  logic [PIX_W-1:0]  pixel_5_i,
  input  logic              row_end_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [BYTE_W-1:0] out_byte_o,
  output logic              is_attribute_o,
  output logic              last_of_run_o
);

  logic              color_mode_q;
  logic [CNT_W-1:0]  lit_thr_q;
  logic [PIX_W-1:0]  held_q [NPIX];
  logic [PIX_W-1:0]  held_d [NPIX];
  logic              held_valid_q, held_valid_d;
  logic [PIX_W-1:0]  cur_color_q, cur_color_d;
  logic [PIX_W-1:0]  in_pix [NPIX];
  lane_t             lanes [NPIX];
  merge_t            mrg;
  logic              accept;
  logic              space2;
  logic [1:0]        push_n;
  res_t              push_d0, push_d1, first_res, second_res, out_res;
  logic [PIX_W-1:0]  cur_mid;

  assign in_pix[0] = pixel_0_i;
  assign in_pix[1] = pixel_1_i;
  assign in_pix[2] = pixel_2_i;
  assign in_pix[3] = pixel_3_i;
  assign in_pix[4] = pixel_4_i;
  assign in_pix[5] = pixel_5_i;

  assign in_ready_o = space2;
  assign accept     = in_valid_i && in_ready_o;

  for (genvar g = 0; g < NPIX; g++) begin : g_lane
    cabe_lane u_lane (
      .held_pix_i (held_q[g]),
      .in_pix_i   (in_pix[g]),
      .lane_o     (lanes[g])
    );
  end

  cabe_merge u_merge (
    .lanes_i (lanes),
    .merge_o (mrg)
  );

  // held cell with incoming cell as lookahead, then incoming cell at row end
  always_comb begin
    cur_mid = cur_color_q;
    if (held_valid_q && mrg.held_cnt < lit_thr_q && cur_color_q != mrg.in_dom) begin
      first_res.out_byte     = BYTE_W'(mrg.in_dom);
      first_res.is_attribute = 1'b1;
      cur_mid                = mrg.in_dom;
    end else begin
      first_res.out_byte     = BITMAP_BASE + BYTE_W'(mrg.held_bmp);
      first_res.is_attribute = 1'b0;
    end
    first_res.last_of_run = !row_end_i;
    if (mrg.in_cnt < lit_thr_q && cur_mid != DEFAULT_COLOR) begin
      second_res.out_byte     = BYTE_W'(DEFAULT_COLOR);
      second_res.is_attribute = 1'b1;
    end else begin
      second_res.out_byte     = BITMAP_BASE + BYTE_W'(mrg.in_bmp);
      second_res.is_attribute = 1'b0;
    end
    second_res.last_of_run = 1'b1;
  end

  always_comb begin
    push_n       = 2'd0;
    push_d0      = second_res;
    push_d1      = second_res;
    held_d       = held_q;
    held_valid_d = held_valid_q;
    cur_color_d  = cur_color_q;
    if (accept) begin
      if (!color_mode_q) begin
        push_n                = 2'd1;
        push_d0.out_byte      = BITMAP_BASE + BYTE_W'(mrg.in_bmp);
        push_d0.is_attribute  = 1'b0;
        push_d0.last_of_run   = 1'b1;
      end else begin
        if (held_valid_q) begin
          push_d0 = first_res;
        end
        push_n = 2'(held_valid_q) + 2'(row_end_i);
        if (row_end_i) begin
          for (int i = 0; i < NPIX; i++) begin
            held_d[i] = '0;
          end
          held_valid_d = 1'b0;
          cur_color_d  = DEFAULT_COLOR;
        end else begin
          held_d       = in_pix;
          held_valid_d = 1'b1;
          cur_color_d  = cur_mid;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      color_mode_q <= 1'b0;
      lit_thr_q    <= '0;
      held_valid_q <= 1'b0;
      cur_color_q  <= DEFAULT_COLOR;
      for (int i = 0; i < NPIX; i++) begin
        held_q[i] <= '0;
      end
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_COLOR_MODE:    color_mode_q <= cfg_wdata_i[0];
          CFG_LIT_THRESHOLD: lit_thr_q    <= cfg_wdata_i;
          default: ;
        endcase
      end
      held_valid_q <= held_valid_d;
      cur_color_q  <= cur_color_d;
      held_q       <= held_d;
    end
  end

  cabe_res_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_n_i    (push_n),
    .push_d0_i   (push_d0),
    .push_d1_i   (push_d1),
    .space2_o    (space2),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_res_o   (out_res)
  );

  assign out_byte_o     = out_res.out_byte;
  assign is_attribute_o = out_res.is_attribute;
  assign last_of_run_o  = out_res.last_of_run;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && color_mode_q && row_end_i) |=>
      (!held_valid_q && cur_color_q == DEFAULT_COLOR))
    else $error("row end did not restart colour state");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && !color_mode_q) |=>
      ($stable(cur_color_q) && $stable(held_valid_q)))
    else $error("mono transaction disturbed colour state");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && is_attribute_o) |-> (out_byte_o != '0 && out_byte_o <= 7'd7))
    else $error("attribute byte out of colour range");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !is_attribute_o) |-> out_byte_o[6])
    else $error("bitmap byte missing base offset");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (lit_thr_q == '0) |-> (push_n == 2'd0 || !push_d0.is_attribute))
    else $error("attribute emitted with zero threshold");

endmodule
